// ===== rtl/krc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krc_pkg: shared types and constants for the Kendall rank correlation core
// Request and result layouts, stored pair layout, fixed field widths.
// ----------------------------------------------------------------------------
package krc_pkg;

  localparam int VALUE_W           = 32;
  localparam int CORR_W            = 18;
  localparam int COMMON_W          = 9;
  localparam int DISC_W            = 16;
  localparam int FRAC_W            = 16;
  // quotient of (d << 18) / (m*(m-1)) never exceeds 2^17
  localparam int QUOT_W            = 18;
  localparam int DEFAULT_MAX_ITEMS = 256;

  localparam logic [DISC_W-1:0] DISC_MAX = '1;
  // 1.0 in Q1.16
  localparam logic [CORR_W-1:0] ONE_Q    = CORR_W'(1) << FRAC_W;

  typedef struct packed {
    logic [VALUE_W-1:0] value_a;
    logic [VALUE_W-1:0] value_b;
    logic               last_item;
  } item_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic [COMMON_W-1:0]      common_count;
  } result_t;

  typedef struct packed {
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
  } pair_t;

endpackage

// ===== rtl/krc_pair_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krc_pair_store: common pair memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module krc_pair_store
  import krc_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_ITEMS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pair_t         wr_data,
  input  logic [AW-1:0] rd_addr,
  output pair_t         rd_data
);

  pair_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/krc_div_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krc_div_unit: serial restoring divider
// Computes floor((d << QUOT_W) / divisor), one quotient bit per cycle.
// Requires d < divisor, which holds since d <= m*(m-1)/2.
// ----------------------------------------------------------------------------
module krc_div_unit
  import krc_pkg::*;
#(
  parameter int DEN_W = 18
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DISC_W-1:0] dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  localparam int STEP_W = $clog2(QUOT_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              running;

  logic [DEN_W:0]    rem_shift;
  logic              fits;

  // shared subtract/compare
  assign rem_shift = {rem, 1'b0};
  assign fits      = rem_shift >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= STEP_W'(QUOT_W);
        rem     <= DEN_W'(dividend);
        dvs     <= divisor;
      end else if (running) begin
        if (fits) begin
          rem <= DEN_W'(rem_shift - {1'b0, dvs});
        end else begin
          rem <= DEN_W'(rem_shift);
        end
        quotient <= {quotient[QUOT_W-2:0], fits};
        steps    <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/kendall_rank_correlation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kendall_rank_correlation_core: streaming Kendall tau over common pairs
// Keeps common (a, b) pairs, counts discordant pairs against the store with
// one shared comparator, and on the last request emits 1 - 4d/(m(m-1)) Q1.16.
//
//   channel   signals                 direction  notes
//   request   start, busy, item       in         taken when start & !busy
//   result    done, result            out        one-cycle strobe, no stall
//
// A request that is not a common pair (or finds the store full) and is not
// last never raises busy. A common pair holds busy while the comparator walks
// the m stored pairs, one memory read per cycle, then stores the pair. A last
// request keeps busy through multiply, divider load, QUOT_W steps and capture,
// or through FINISH alone when m < 2; done strobes in the first cycle after
// busy. Reset empties the pair count; no memory clearing is needed. No stalls.
// ----------------------------------------------------------------------------
module kendall_rank_correlation_core
  import krc_pkg::*;
#(
  parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int DEN_W = 2 * CNT_W;

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    WRITE,
    FINISH,
    DIV
  } state_t;

  state_t            state;
  item_t             cur;
  logic [CNT_W-1:0]  count;
  logic [DISC_W-1:0] disc;
  logic [AW-1:0]     idx;
  logic              rd_pend;
  logic [DEN_W-1:0]  denom;
  logic              div_start;

  pair_t             rd_data;
  pair_t             wr_data;
  logic              wr_en;
  logic              div_done;
  logic [QUOT_W-1:0] quot;

  logic              accept;
  logic              is_common;
  logic              has_room;
  logic              disagree;
  logic [DEN_W-1:0]  count_ext;
  logic [DEN_W-1:0]  denom_next;
  logic [CORR_W:0]   corr_wide;

  assign busy      = (state != IDLE);
  assign accept    = start && !busy;
  assign is_common = (item.value_a != '0) && (item.value_b != '0);
  assign has_room  = count < CNT_W'(MAX_ITEMS);

  // store write of the new pair
  assign wr_en     = (state == WRITE);
  assign wr_data   = '{a: cur.value_a, b: cur.value_b};

  // shared comparator: new pair against one stored pair
  assign disagree = ((cur.value_a > rd_data.a) && (cur.value_b < rd_data.b)) ||
                    ((cur.value_a < rd_data.a) && (cur.value_b > rd_data.b));

  // m * (m - 1), registered before the divider
  assign count_ext  = DEN_W'(count);
  assign denom_next = count_ext * (count_ext - DEN_W'(1));

  // 1.0 - quotient
  assign corr_wide = {1'b0, ONE_Q} - {1'b0, quot};

  krc_pair_store #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  krc_div_unit #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (disc),
    .divisor  (denom),
    .done     (div_done),
    .quotient (quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      disc      <= '0;
      idx       <= '0;
      rd_pend   <= 1'b0;
      div_start <= 1'b0;
      done      <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      rd_pend   <= 1'b0;

      // tally the stored pair read last cycle
      if (rd_pend && disagree && (disc != DISC_MAX)) begin
        disc <= disc + 1'b1;
      end

      case (state)
        IDLE: begin
          if (accept) begin
            cur <= item;
            idx <= '0;
            if (is_common && has_room) begin
              state <= (count == '0) ? WRITE : SCAN;
            end else if (item.last_item) begin
              state <= FINISH;
            end
          end
        end

        SCAN: begin
          rd_pend <= 1'b1;
          idx     <= idx + 1'b1;
          if (CNT_W'(idx) == count - 1'b1) begin
            state <= WRITE;
          end
        end

        WRITE: begin
          count <= count + 1'b1;
          state <= cur.last_item ? FINISH : IDLE;
        end

        FINISH: begin
          if (count < CNT_W'(2)) begin
            result.correlation  <= '0;
            result.common_count <= COMMON_W'(count);
            done  <= 1'b1;
            count <= '0;
            disc  <= '0;
            state <= IDLE;
          end else begin
            denom     <= denom_next;
            div_start <= 1'b1;
            state     <= DIV;
          end
        end

        DIV: begin
          if (div_done) begin
            result.correlation  <= $signed(corr_wide[CORR_W-1:0]);
            result.common_count <= COMMON_W'(count);
            done  <= 1'b1;
            count <= '0;
            disc  <= '0;
            state <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
